// ----- sv/trgb5a3_pkg.sv -----
// Shared types, constants and channel scaling tables for the tiled RGB5A3 decoder.
`default_nettype none

package trgb5a3_pkg;

  localparam int DIM_W   = 11;  // width of the image size registers
  localparam int COORD_W = 10;  // width of a pixel coordinate

  localparam logic [DIM_W-1:0] MAX_DIM     = 11'd1024;
  localparam logic [DIM_W-1:0] TILE_STEP   = 11'd4;
  localparam logic [1:0]       TILE_LAST   = 2'd3;    // last column/row inside a tile
  localparam int               FMT_BIT     = 15;      // set: RGB555, clear: RGB444A3
  localparam logic [7:0]       ALPHA_OPAQUE = 8'd255;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd96;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd32;

  // Register index codes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [15:0] pixel_word;
    logic        start_image;
  } texel_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } pixel_t;

  // Position of the texel being taken, and whether it lies inside the image
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               hit;
  } walk_pos_t;

  // floor(v * 255 / 31)
  function automatic logic [7:0] scale5(input logic [4:0] v);
    logic [7:0] s;
    case (v)
      5'd0:  s = 8'd0;    5'd1:  s = 8'd8;    5'd2:  s = 8'd16;   5'd3:  s = 8'd24;
      5'd4:  s = 8'd32;   5'd5:  s = 8'd41;   5'd6:  s = 8'd49;   5'd7:  s = 8'd57;
      5'd8:  s = 8'd65;   5'd9:  s = 8'd74;   5'd10: s = 8'd82;   5'd11: s = 8'd90;
      5'd12: s = 8'd98;   5'd13: s = 8'd106;  5'd14: s = 8'd115;  5'd15: s = 8'd123;
      5'd16: s = 8'd131;  5'd17: s = 8'd139;  5'd18: s = 8'd148;  5'd19: s = 8'd156;
      5'd20: s = 8'd164;  5'd21: s = 8'd172;  5'd22: s = 8'd180;  5'd23: s = 8'd189;
      5'd24: s = 8'd197;  5'd25: s = 8'd205;  5'd26: s = 8'd213;  5'd27: s = 8'd222;
      5'd28: s = 8'd230;  5'd29: s = 8'd238;  5'd30: s = 8'd246;  default: s = 8'd255;
    endcase
    return s;
  endfunction

  // v * 255 / 15 is exactly v * 17
  function automatic logic [7:0] scale4(input logic [3:0] v);
    return {v, v};
  endfunction

  // floor(v * 255 / 7)
  function automatic logic [7:0] scale3(input logic [2:0] v);
    logic [7:0] s;
    case (v)
      3'd0: s = 8'd0;
      3'd1: s = 8'd36;
      3'd2: s = 8'd72;
      3'd3: s = 8'd109;
      3'd4: s = 8'd145;
      3'd5: s = 8'd182;
      3'd6: s = 8'd218;
      default: s = 8'd255;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- sv/trgb5a3_walk.sv -----
// Tile walk position tracker: 4x4 tiles, row of tiles by row of tiles.
`default_nettype none

module trgb5a3_walk
  import trgb5a3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,      // texel taken this cycle
  input  wire logic             start_image,  // texel is pixel 0,0
  input  wire logic [DIM_W-1:0] image_width,
  input  wire logic [DIM_W-1:0] image_height,
  output walk_pos_t             pos
);

  logic [COORD_W-1:0] tile_col_base, tile_col_base_next;
  logic [COORD_W-1:0] tile_row_base, tile_row_base_next;
  logic [1:0]         in_tile_col, in_tile_col_next;
  logic [1:0]         in_tile_row, in_tile_row_next;

  logic [COORD_W-1:0] cur_col, cur_row;
  logic [1:0]         cur_icol, cur_irow;
  logic [DIM_W-1:0]   w, h, col_sum, row_sum;

  always_comb begin
    w = (image_width  > MAX_DIM) ? MAX_DIM : image_width;
    h = (image_height > MAX_DIM) ? MAX_DIM : image_height;

    cur_col  = start_image ? '0 : tile_col_base;
    cur_row  = start_image ? '0 : tile_row_base;
    cur_icol = start_image ? '0 : in_tile_col;
    cur_irow = start_image ? '0 : in_tile_row;

    // bases are tile aligned, so the in-tile offset never carries
    pos.x   = cur_col + COORD_W'(cur_icol);
    pos.y   = cur_row + COORD_W'(cur_irow);
    pos.hit = ({1'b0, pos.x} < w) && ({1'b0, pos.y} < h);

    col_sum = {1'b0, cur_col} + TILE_STEP;
    row_sum = {1'b0, cur_row} + TILE_STEP;

    tile_col_base_next = cur_col;
    tile_row_base_next = cur_row;
    in_tile_col_next   = cur_icol + 2'd1;
    in_tile_row_next   = cur_irow;
    if (cur_icol == TILE_LAST) begin
      in_tile_row_next = cur_irow + 2'd1;
      if (cur_irow == TILE_LAST) begin
        if (col_sum >= w) begin
          tile_col_base_next = '0;
          tile_row_base_next = (row_sum >= h) ? '0 : row_sum[COORD_W-1:0];
        end else begin
          tile_col_base_next = col_sum[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_col_base <= '0;
      tile_row_base <= '0;
      in_tile_col   <= '0;
      in_tile_row   <= '0;
    end else if (advance) begin
      tile_col_base <= tile_col_base_next;
      tile_row_base <= tile_row_base_next;
      in_tile_col   <= in_tile_col_next;
      in_tile_row   <= in_tile_row_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tiled_rgb5a3_to_rgba_decoder.sv -----
// Top level: tiled RGB5A3 texel stream to RGBA8888 pixels with coordinates.
`default_nettype none

// Takes one 16-bit texel per clock on the texel channel and returns decoded
// RGBA pixels with their x,y position on the pixel channel. Texels arrive in
// 4x4 tiles, tiles left to right then tile row by tile row; start_image puts
// a texel at pixel 0,0. Texels outside image_width x image_height (padding)
// advance the walk but yield no pixel. Sustained rate is one texel per cycle,
// absent a pixel stall, through the input and result registers of the
// two-stage pipeline. A stall on the pixel side backs up through both stages,
// so up to two pixels may be held while the texel side stalls. Sizes above
// 1024 act as 1024. Configuration is over an APB port: image_width at 0x0,
// image_height at 0x4, 11 bits each, reset 96 and 32; write only while idle.

module tiled_rgb5a3_to_rgba_decoder
  import trgb5a3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // texel transaction in
  input  wire logic        texel_valid,
  output logic             texel_stall,
  input  wire texel_t      texel,
  // pixel transaction out
  output logic             pixel_valid,
  input  wire logic        pixel_stall,
  output pixel_t           pixel,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------- configuration registers ----------------
  logic [DIM_W-1:0] image_width, image_height;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, image_width};
      REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, image_height};
      default:    prdata = '0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  // Stage 1 holds the texel and its position; stage 2 is the pixel register.
  logic s1_valid;
  logic out_free, s1_free, texel_take;

  assign out_free    = !pixel_valid || !pixel_stall;
  assign s1_free     = !s1_valid || out_free;
  assign texel_stall = !s1_free;
  assign texel_take  = texel_valid && s1_free;

  // ---------------- tile walk ----------------
  walk_pos_t pos;

  trgb5a3_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .advance      (texel_take),
    .start_image  (texel.start_image),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (pos)
  );

  // ---------------- stage 1: input register ----------------
  // Only texels inside the image enter; padding texels drop here.
  logic [15:0]        s1_word;
  logic [COORD_W-1:0] s1_x, s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= texel_take && pos.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (texel_take) begin
      s1_word <= texel.pixel_word;
      s1_x    <= pos.x;
      s1_y    <= pos.y;
    end
  end

  // ---------------- color decode ----------------
  pixel_t decoded;

  always_comb begin
    decoded.pixel_x = s1_x;
    decoded.pixel_y = s1_y;
    if (s1_word[FMT_BIT]) begin
      // RGB555, opaque
      decoded.red   = scale5(s1_word[14:10]);
      decoded.green = scale5(s1_word[9:5]);
      decoded.blue  = scale5(s1_word[4:0]);
      decoded.alpha = ALPHA_OPAQUE;
    end else begin
      // RGB444 with 3-bit alpha; bit 3 unused
      decoded.red   = scale4(s1_word[15:12]);
      decoded.green = scale4(s1_word[11:8]);
      decoded.blue  = scale4(s1_word[7:4]);
      decoded.alpha = scale3(s1_word[2:0]);
    end
  end

  // ---------------- stage 2: result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (out_free) begin
      pixel_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      pixel <= decoded;
    end
  end

endmodule

`default_nettype wire
